// ----- hdl/rpr_pkg.sv -----
// Shared types and constants for the rotary position rotation block.
// Holds the per-pair phase-step ROM, built at elaboration, and the Horner cell constants.
// No dependencies.
package rpr_pkg;

   localparam int ATTN_DIM   = 64;
   localparam int HALF_PAIRS = ATTN_DIM / 2;
   localparam int DATA_BITS  = 16;
   localparam int POS_BITS   = 12;
   localparam int PAIR_BITS  = 5;
   localparam int STEP_BITS  = 32;
   localparam int TRIG_W     = 16;
   localparam int TRIG_FRAC  = 15;

   // tdata field layout, lowest bit first
   localparam int POS_LSB     = 0;
   localparam int PAIR_LSB    = POS_LSB + POS_BITS;
   localparam int FIRST_LSB   = PAIR_LSB + PAIR_BITS;
   localparam int SECOND_LSB  = FIRST_LSB + DATA_BITS;
   localparam int REQ_BITS    = SECOND_LSB + DATA_BITS;
   localparam int REQ_DATA_W  = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W  = 2 * DATA_BITS;

   // Product and rounding widths of the rotation
   localparam int PROD_W = DATA_BITS + TRIG_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int RND_W  = SUM_W + 1;
   localparam int SHR_W  = RND_W - TRIG_FRAC;

   localparam logic [30:0] Q30_ONE          = 31'h4000_0000;
   localparam logic [29:0] EIGHTH_TURN      = 30'h2000_0000;
   localparam logic [30:0] HALF_PI_Q30      = 31'd1686629713;
   localparam logic [63:0] TURN_PER_RAD_Q32 = 64'd683565276;
   localparam logic [63:0] INV_BASE_Q32     = 64'd429497;

   // Quadrant of the phase and rotation direction
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;
   localparam logic       MODE_FORWARD  = 1'b0;
   localparam logic       MODE_BACKWARD = 1'b1;

   localparam int CELL_STAGES = 3;
   localparam int SIN_CELLS   = 3;
   localparam int COS_CELLS   = 4;

   typedef logic [29:0] frac_type;
   typedef logic [30:0] q30_type;
   typedef logic signed [DATA_BITS-1:0] data_type;
   typedef logic signed [TRIG_W-1:0] trig_type;

   localparam data_type DATA_MAX = data_type'(2 ** (DATA_BITS - 1) - 1);
   localparam data_type DATA_MIN = data_type'(-(2 ** (DATA_BITS - 1)));

   // Divisor of one Horner step and its reciprocal floor(2^32 / divisor)
   typedef struct packed {
      logic [5:0]  divisor;
      logic [31:0] recip;
   } div_type;

   typedef struct packed {
      data_type first;
      data_type second;
      logic     sat;
   } res_type;

   localparam div_type SIN_DIV [SIN_CELLS] = '{
      '{divisor: 6'd42, recip: 32'(64'h1_0000_0000 / 64'd42)},
      '{divisor: 6'd20, recip: 32'(64'h1_0000_0000 / 64'd20)},
      '{divisor: 6'd6,  recip: 32'(64'h1_0000_0000 / 64'd6)}
   };

   localparam div_type COS_DIV [COS_CELLS] = '{
      '{divisor: 6'd56, recip: 32'(64'h1_0000_0000 / 64'd56)},
      '{divisor: 6'd30, recip: 32'(64'h1_0000_0000 / 64'd30)},
      '{divisor: 6'd12, recip: 32'(64'h1_0000_0000 / 64'd12)},
      '{divisor: 6'd2,  recip: 32'(64'h1_0000_0000 / 64'd2)}
   };

   function automatic logic [63:0] pow_q32(input logic [63:0] r, input int n);
      logic [63:0] acc;
      acc = 64'h1_0000_0000;
      for (int i = 0; i < n; i++) begin
         acc = (acc * r) >> 32;
      end
      return acc;
   endfunction

   // Largest Q0.32 ratio whose truncated HALF_PAIRS-th power stays at or below 1/10000
   function automatic logic [63:0] find_ratio();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lo = '0;
      hi = 64'hFFFF_FFFF;
      while (lo < hi) begin
         mid = lo + ((hi - lo + 64'd1) >> 1);
         if (pow_q32(mid, HALF_PAIRS) <= INV_BASE_Q32) begin
            lo = mid;
         end else begin
            hi = mid - 64'd1;
         end
      end
      return lo;
   endfunction

   localparam logic [63:0] RATIO_Q32 = find_ratio();

   function automatic logic [HALF_PAIRS*STEP_BITS-1:0] build_freq_table();
      logic [HALF_PAIRS*STEP_BITS-1:0] tbl;
      logic [63:0] g;
      logic [63:0] v;
      tbl = '0;
      g = 64'h1_0000_0000;
      for (int k = 0; k < HALF_PAIRS; k++) begin
         v = (TURN_PER_RAD_Q32 * g + 64'h8000_0000) >> 32;
         tbl[k*STEP_BITS +: STEP_BITS] = v[STEP_BITS-1:0];
         g = (g * RATIO_Q32) >> 32;
      end
      return tbl;
   endfunction

   // Phase step per position for each pair index, in 2^-32 turn
   localparam logic [HALF_PAIRS*STEP_BITS-1:0] FREQ_TABLE = build_freq_table();

endpackage

// ----- hdl/rotary_position_rotation.sv -----
// Top level of the rotary position rotation block: phase front end, sine and cosine
// cell chains, rotation datapath and output skid. Depends on rpr_pkg, rpr_cell, rpr_skid.
//
// Each transaction carries an element pair, its sequence position and its pair index; the
// pair is rotated by position times the pair's inverse frequency (negated in backward mode),
// rounded and saturated, with rsp_tuser flagging a clip. The block takes one transaction
// per clock while req_tready is high and returns results in order through 22 registers:
// five in the phase front end, the cosine chain of four Horner cells with three registers
// each, four rotation stages and the output register. A stalled result is held in the
// output register and one skid entry, and req_tready falls only when both are full.
module rotary_position_rotation import rpr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // position, pair_index, first_value, second_value, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rotated_first, rotated_second
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // saturated
   output logic                  rsp_tuser
);

   localparam int PHASE_STAGE  = 1;
   localparam int FOLD_STAGE   = 2;
   localparam int ANGLE_STAGE  = 3;
   localparam int SQUARE_STAGE = 4;
   localparam int PIPE_DEPTH   = SQUARE_STAGE + 1 + COS_CELLS * CELL_STAGES;
   localparam int SIN_TAP      = SQUARE_STAGE + SIN_CELLS * CELL_STAGES;
   localparam int SIN_DLY      = (COS_CELLS - SIN_CELLS) * CELL_STAGES;
   localparam int HALF_LSB     = 2 ** (TRIG_FRAC - 1);

   localparam logic signed [SHR_W-1:0] SAT_HI = SHR_W'(DATA_MAX);
   localparam logic signed [SHR_W-1:0] SAT_LO = SHR_W'(DATA_MIN);

   typedef struct packed {
      logic                 mode;
      logic [POS_BITS-1:0]  pos;
      logic [STEP_BITS-1:0] step;
      logic [STEP_BITS-1:0] phase;
      logic [1:0]           quad;
      logic                 swap;
      frac_type             fold;
      frac_type             angle;
      frac_type             x2;
      data_type             first;
      data_type             second;
   } side_type;

   function automatic logic [14:0] to_q15(input q30_type v);
      logic [31:0] r;
      r = 32'(v) + 32'(HALF_LSB);
      return (r[31:15] > 17'd32767) ? 15'h7FFF : r[29:15];
   endfunction

   // {clip, value}: round half up by 2^-15, then saturate
   function automatic logic [DATA_BITS:0] round_sat(input logic signed [SUM_W-1:0] acc);
      logic signed [RND_W-1:0] rnd;
      logic signed [SHR_W-1:0] r;
      logic [DATA_BITS:0]      res;
      rnd = RND_W'(acc) + RND_W'(HALF_LSB);
      r   = rnd[RND_W-1:TRIG_FRAC];
      if (r > SAT_HI) begin
         res = {1'b1, DATA_MAX};
      end else if (r < SAT_LO) begin
         res = {1'b1, DATA_MIN};
      end else begin
         res = {1'b0, r[DATA_BITS-1:0]};
      end
      return res;
   endfunction

   logic pipe_en;

   // Front end and alignment line
   side_type pipe_ff [PIPE_DEPTH];
   side_type pipe_in [PIPE_DEPTH];
   logic     valid_ff [PIPE_DEPTH];
   logic     valid_in [PIPE_DEPTH];

   logic [PAIR_BITS-1:0]   pair;
   logic [43:0]            phase_prod;
   logic [29:0]            phase_low;
   logic [30:0]            fold_wide;
   logic [60:0]            angle_prod;
   logic [59:0]            sq_prod;

   always_comb begin
      pair = req_tdata[PAIR_LSB +: PAIR_BITS];
      pipe_in[0]        = '0;
      pipe_in[0].mode   = req_tuser;
      pipe_in[0].pos    = req_tdata[POS_LSB +: POS_BITS];
      pipe_in[0].first  = req_tdata[FIRST_LSB +: DATA_BITS];
      pipe_in[0].second = req_tdata[SECOND_LSB +: DATA_BITS];
      pipe_in[0].step   = (8'(pair) < 8'(HALF_PAIRS)) ? FREQ_TABLE[{pair, 5'd0} +: STEP_BITS]
                                                      : '0;
      valid_in[0] = req_tvalid;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
         pipe_in[i]  = pipe_ff[i-1];
         valid_in[i] = valid_ff[i-1];
      end

      phase_prod = 44'(pipe_ff[PHASE_STAGE-1].pos) * 44'(pipe_ff[PHASE_STAGE-1].step);
      pipe_in[PHASE_STAGE].phase = phase_prod[STEP_BITS-1:0];

      // fold the quarter turn onto [0, 1/8] turn
      phase_low = pipe_ff[FOLD_STAGE-1].phase[29:0];
      fold_wide = Q30_ONE - {1'b0, phase_low};
      pipe_in[FOLD_STAGE].quad = pipe_ff[FOLD_STAGE-1].phase[31:30];
      pipe_in[FOLD_STAGE].swap = phase_low > EIGHTH_TURN;
      pipe_in[FOLD_STAGE].fold = (phase_low > EIGHTH_TURN) ? fold_wide[29:0] : phase_low;

      angle_prod = 61'(pipe_ff[ANGLE_STAGE-1].fold) * 61'(HALF_PI_Q30);
      pipe_in[ANGLE_STAGE].angle = angle_prod[59:30];

      sq_prod = 60'(pipe_ff[SQUARE_STAGE-1].angle) * 60'(pipe_ff[SQUARE_STAGE-1].angle);
      pipe_in[SQUARE_STAGE].x2 = sq_prod[59:30];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (pipe_en) begin
            valid_ff[i] <= valid_in[i];
         end
         if (pipe_en) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   // Horner chains; cell n reads x2 from the line where its term arrives
   q30_type sin_term [SIN_CELLS];
   q30_type cos_term [COS_CELLS];

   for (genvar n = 0; n < SIN_CELLS; n++) begin : g_sin
      if (n == 0) begin : g_head
         rpr_cell u_cell (
            .clock     (clock),
            .advance   (pipe_en),
            .x2_sq     (pipe_ff[SQUARE_STAGE].x2),
            .term_prev (Q30_ONE),
            .div_const (SIN_DIV[n]),
            .term_next (sin_term[n])
         );
      end else begin : g_body
         rpr_cell u_cell (
            .clock     (clock),
            .advance   (pipe_en),
            .x2_sq     (pipe_ff[SQUARE_STAGE + n * CELL_STAGES].x2),
            .term_prev (sin_term[n-1]),
            .div_const (SIN_DIV[n]),
            .term_next (sin_term[n])
         );
      end
   end

   for (genvar n = 0; n < COS_CELLS; n++) begin : g_cos
      if (n == 0) begin : g_head
         rpr_cell u_cell (
            .clock     (clock),
            .advance   (pipe_en),
            .x2_sq     (pipe_ff[SQUARE_STAGE].x2),
            .term_prev (Q30_ONE),
            .div_const (COS_DIV[n]),
            .term_next (cos_term[n])
         );
      end else begin : g_body
         rpr_cell u_cell (
            .clock     (clock),
            .advance   (pipe_en),
            .x2_sq     (pipe_ff[SQUARE_STAGE + n * CELL_STAGES].x2),
            .term_prev (cos_term[n-1]),
            .div_const (COS_DIV[n]),
            .term_next (cos_term[n])
         );
      end
   end

   // Final sine multiply, then hold until the cosine chain catches up
   q30_type     sin_dly_ff [SIN_DLY];
   logic [60:0] sin_prod;

   assign sin_prod = 61'(pipe_ff[SIN_TAP].angle) * 61'(sin_term[SIN_CELLS-1]);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         sin_dly_ff[0] <= sin_prod[60:30];
         for (int i = 1; i < SIN_DLY; i++) begin
            sin_dly_ff[i] <= sin_dly_ff[i-1];
         end
      end
   end

   // Rotation stages
   logic        e_valid_ff, f_valid_ff, g_valid_ff, h_valid_ff;
   logic [14:0] e_s0_ff, e_c0_ff, sin_q, cos_q;
   logic [1:0]  e_quad_ff;
   logic        e_mode_ff;
   data_type    e_first_ff, e_second_ff, f_first_ff, f_second_ff;
   trig_type    f_sin_ff, f_cos_ff, f_sin_in, f_cos_in, sw, cw;
   logic signed [PROD_W-1:0] g_xc_ff, g_ys_ff, g_xs_ff, g_yc_ff;
   logic signed [SUM_W-1:0]  h_a_ff, h_b_ff;
   logic [DATA_BITS:0]       sat_a, sat_b;
   res_type                  pipe_res;
   res_type                  out_res;

   always_comb begin
      sin_q = to_q15(sin_dly_ff[SIN_DLY-1]);
      cos_q = to_q15(cos_term[COS_CELLS-1]);
      sw = $signed({1'b0, e_s0_ff});
      cw = $signed({1'b0, e_c0_ff});
      case (e_quad_ff)
         QUAD_0: begin
            f_sin_in = sw;
            f_cos_in = cw;
         end
         QUAD_1: begin
            f_sin_in = cw;
            f_cos_in = -sw;
         end
         QUAD_2: begin
            f_sin_in = -sw;
            f_cos_in = -cw;
         end
         QUAD_3: begin
            f_sin_in = -cw;
            f_cos_in = sw;
         end
         default: begin
            f_sin_in = sw;
            f_cos_in = cw;
         end
      endcase
      if (e_mode_ff == MODE_BACKWARD) begin
         f_sin_in = -f_sin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         e_valid_ff <= valid_ff[PIPE_DEPTH-1];
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
         h_valid_ff <= g_valid_ff;
      end
      if (pipe_en) begin
         // undo the eighth-turn fold
         e_s0_ff     <= pipe_ff[PIPE_DEPTH-1].swap ? cos_q : sin_q;
         e_c0_ff     <= pipe_ff[PIPE_DEPTH-1].swap ? sin_q : cos_q;
         e_quad_ff   <= pipe_ff[PIPE_DEPTH-1].quad;
         e_mode_ff   <= pipe_ff[PIPE_DEPTH-1].mode;
         e_first_ff  <= pipe_ff[PIPE_DEPTH-1].first;
         e_second_ff <= pipe_ff[PIPE_DEPTH-1].second;
         f_sin_ff    <= f_sin_in;
         f_cos_ff    <= f_cos_in;
         f_first_ff  <= e_first_ff;
         f_second_ff <= e_second_ff;
         g_xc_ff     <= PROD_W'(f_first_ff) * PROD_W'(f_cos_ff);
         g_ys_ff     <= PROD_W'(f_second_ff) * PROD_W'(f_sin_ff);
         g_xs_ff     <= PROD_W'(f_first_ff) * PROD_W'(f_sin_ff);
         g_yc_ff     <= PROD_W'(f_second_ff) * PROD_W'(f_cos_ff);
         h_a_ff      <= SUM_W'(g_xc_ff) - SUM_W'(g_ys_ff);
         h_b_ff      <= SUM_W'(g_xs_ff) + SUM_W'(g_yc_ff);
      end
   end

   always_comb begin
      sat_a = round_sat(h_a_ff);
      sat_b = round_sat(h_b_ff);
      pipe_res.first  = sat_a[DATA_BITS-1:0];
      pipe_res.second = sat_b[DATA_BITS-1:0];
      pipe_res.sat    = sat_a[DATA_BITS] | sat_b[DATA_BITS];
   end

   rpr_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (h_valid_ff),
      .in_res    (pipe_res),
      .in_ready  (pipe_en),
      .out_valid (rsp_tvalid),
      .out_res   (out_res),
      .out_ready (rsp_tready)
   );

   assign req_tready = pipe_en;
   assign rsp_tdata  = {out_res.second, out_res.first};
   assign rsp_tuser  = out_res.sat;

`ifndef SYNTH
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   a_flag_means_clip: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata[DATA_BITS-1:0] == DATA_MAX || rsp_tdata[DATA_BITS-1:0] == DATA_MIN ||
          rsp_tdata[RSP_DATA_W-1:DATA_BITS] == DATA_MAX ||
          rsp_tdata[RSP_DATA_W-1:DATA_BITS] == DATA_MIN))
      else $error("saturation flag set on an unclipped result");

   a_line_to_rotation: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[PIPE_DEPTH-1] && req_tready) |=> e_valid_ff)
      else $error("transaction lost between cell chains and rotation");

   a_rotation_to_output: assert property (@(posedge clock) disable iff (reset)
      (h_valid_ff && req_tready) |=> rsp_tvalid)
      else $error("finished transaction lost at the output");
`endif

endmodule

// ----- hdl/rpr_cell.sv -----
// One Horner step of the sine/cosine polynomial: term_next = 1 - (x2 * term_prev) / divisor.
// Three register stages: product, reciprocal quotient, quotient correction.
// Depends on rpr_pkg.
module rpr_cell import rpr_pkg::*; (
   input  logic     clock,
   input  logic     advance,
   input  frac_type x2_sq,
   input  q30_type  term_prev,
   input  div_type  div_const,
   output q30_type  term_next
);

   q30_type prod_ff, prod_in;
   q30_type part_ff;
   q30_type quo_ff, quo_in;
   q30_type term_ff, term_in;

   logic [60:0] mul_sq;
   logic [62:0] mul_recip;
   logic [36:0] mul_back;
   logic [36:0] rem_wide;
   logic        fix_up;

   always_comb begin
      mul_sq    = 61'(x2_sq) * 61'(term_prev);
      prod_in   = mul_sq[60:30];
      mul_recip = 63'(prod_ff) * 63'(div_const.recip);
      quo_in    = mul_recip[62:32];
      // reciprocal estimate is at most one short: check the remainder once
      mul_back  = 37'(quo_ff) * 37'(div_const.divisor);
      rem_wide  = 37'(part_ff) - mul_back;
      fix_up    = rem_wide[30:0] >= 31'(div_const.divisor);
      term_in   = Q30_ONE - (quo_ff + 31'(fix_up));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         part_ff <= prod_ff;
         quo_ff  <= quo_in;
         term_ff <= term_in;
      end
   end

   assign term_next = term_ff;

endmodule

// ----- hdl/rpr_skid.sv -----
// Output register with one skid entry for the result channel.
// Keeps the pipeline moving while a finished result waits. Depends on rpr_pkg.
module rpr_skid import rpr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  res_type in_res,
   output logic    in_ready,
   output logic    out_valid,
   output res_type out_res,
   input  logic    out_ready
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   res_type out_res_ff, out_res_in;
   res_type skid_res_ff, skid_res_in;
   logic    take;
   logic    out_free;

   always_comb begin
      take          = in_valid & ~skid_valid_ff;
      out_free      = ~out_valid_ff | out_ready;
      out_valid_in  = out_valid_ff;
      out_res_in    = out_res_ff;
      skid_valid_in = skid_valid_ff;
      skid_res_in   = skid_res_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_res_in    = skid_res_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = take;
            out_res_in   = in_res;
         end
      end else if (take) begin
         // park the arriving transaction behind the stalled one
         skid_valid_in = 1'b1;
         skid_res_in   = in_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_res_ff  <= out_res_in;
      skid_res_ff <= skid_res_in;
   end

   assign in_ready  = ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_res   = out_res_ff;

endmodule

// ----- test/rotary_position_rotation_check.sv -----
// Checker for the rotary position rotation block: watches both stream channels, predicts
// each rotated pair in fixed point and compares it with the result that comes back.
// Depends on rpr_pkg for field widths, tdata layout and the result type.
module rotary_position_rotation_check import rpr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   output int                    mismatches,
   output int                    outstanding,
   output int                    results_seen,
   output int                    clipped_seen
);

   localparam longint unsigned UNIT_Q30 = 64'h4000_0000;

   logic [31:0] step_rom [HALF_PAIRS];
   res_type     rotated_q [$];

   function automatic longint unsigned ratio_power(longint unsigned r);
      longint unsigned acc;
      acc = 64'h1_0000_0000;
      for (int i = 0; i < HALF_PAIRS; i++) begin
         acc = (acc * r) >> 32;
      end
      return acc;
   endfunction

   function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
      return (a * b) >> 30;
   endfunction

   function automatic longint unsigned sine_q30(longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      x2 = q30_mul(x, x);
      t = UNIT_Q30 - x2 / 42;
      t = UNIT_Q30 - q30_mul(x2, t) / 20;
      t = UNIT_Q30 - q30_mul(x2, t) / 6;
      return q30_mul(x, t);
   endfunction

   function automatic longint unsigned cosine_q30(longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      x2 = q30_mul(x, x);
      t = UNIT_Q30 - x2 / 56;
      t = UNIT_Q30 - q30_mul(x2, t) / 30;
      t = UNIT_Q30 - q30_mul(x2, t) / 12;
      return UNIT_Q30 - q30_mul(x2, t) / 2;
   endfunction

   // Round half up to Q1.15; cos(0) lands on 1.0 and is clipped
   function automatic longint to_q15(longint unsigned v);
      longint unsigned r;
      r = (v + 64'd16384) >> 15;
      return (r > 64'd32767) ? 64'sd32767 : longint'(r);
   endfunction

   function automatic data_type round_clip(longint acc, inout logic clip);
      longint r;
      r = (acc + 64'sd16384) >>> 15;
      if (r > 64'sd32767) begin
         clip = 1'b1;
         return DATA_MAX;
      end
      if (r < -64'sd32768) begin
         clip = 1'b1;
         return DATA_MIN;
      end
      return data_type'(r);
   endfunction

   function automatic res_type rotate_pair(logic backward, logic [POS_BITS-1:0] pos,
                                           logic [PAIR_BITS-1:0] k, data_type x, data_type y);
      longint unsigned phase_step;
      longint unsigned phase;
      longint unsigned u;
      longint unsigned arg;
      longint s0, c0, s, c;
      logic [1:0] quad;
      logic clip;
      res_type r;
      clip = 1'b0;
      phase_step = (k < HALF_PAIRS) ? longint'(step_rom[k]) : 64'd0;
      phase = (longint'(pos) * phase_step) & 64'hFFFF_FFFF;
      quad = phase[31:30];
      u = phase & 64'h3FFF_FFFF;
      // fold the upper half of each quadrant back onto [0, pi/4]
      if (u <= 64'h2000_0000) begin
         arg = (u * HALF_PI_Q30) >> 30;
         s0 = to_q15(sine_q30(arg));
         c0 = to_q15(cosine_q30(arg));
      end else begin
         arg = ((UNIT_Q30 - u) * HALF_PI_Q30) >> 30;
         s0 = to_q15(cosine_q30(arg));
         c0 = to_q15(sine_q30(arg));
      end
      case (quad)
         QUAD_0: begin s = s0;  c = c0;  end
         QUAD_1: begin s = c0;  c = -s0; end
         QUAD_2: begin s = -s0; c = -c0; end
         default: begin s = -c0; c = s0; end
      endcase
      if (backward == MODE_BACKWARD) begin
         s = -s;
      end
      r.first  = round_clip(longint'(x) * c - longint'(y) * s, clip);
      r.second = round_clip(longint'(x) * s + longint'(y) * c, clip);
      r.sat    = clip;
      return r;
   endfunction

   // Phase step per position: ratio r with r^(ATTN_DIM/2) just under 1/10000
   initial begin
      longint unsigned lo, hi, mid, g;
      lo = 0;
      hi = 64'hFFFF_FFFF;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         if (ratio_power(mid) <= INV_BASE_Q32) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      g = 64'h1_0000_0000;
      for (int k = 0; k < HALF_PAIRS; k++) begin
         step_rom[k] = 32'((TURN_PER_RAD_Q32 * g + 64'h8000_0000) >> 32);
         g = (g * lo) >> 32;
      end
   end

   initial begin
      mismatches   = 0;
      outstanding  = 0;
      results_seen = 0;
      clipped_seen = 0;
   end

   always @(posedge clock) begin
      res_type want;
      res_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.first  = rsp_tdata[DATA_BITS-1:0];
            got.second = rsp_tdata[2*DATA_BITS-1:DATA_BITS];
            got.sat    = rsp_tuser;
            results_seen <= results_seen + 1;
            if (got.sat) begin
               clipped_seen <= clipped_seen + 1;
            end
            if (rotated_q.size() == 0) begin
               if (mismatches < 10) begin
                  $display("unexpected result transaction: first %0d second %0d sat %0b",
                           got.first, got.second, got.sat);
               end
               mismatches <= mismatches + 1;
            end else begin
               want = rotated_q.pop_front();
               if (got !== want) begin
                  if (mismatches < 10) begin
                     $display("result %0d mismatch: expected first %0d second %0d sat %0b,",
                              results_seen, want.first, want.second, want.sat,
                              " got first %0d second %0d sat %0b",
                              got.first, got.second, got.sat);
                  end
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            rotated_q.push_back(rotate_pair(req_tuser,
                                            req_tdata[POS_LSB +: POS_BITS],
                                            req_tdata[PAIR_LSB +: PAIR_BITS],
                                            req_tdata[FIRST_LSB +: DATA_BITS],
                                            req_tdata[SECOND_LSB +: DATA_BITS]));
         end
         outstanding <= rotated_q.size();
      end
   end

endmodule

// ----- test/rotary_position_rotation_test.sv -----
// Top of the rotary position rotation testbench: clock, reset, stimulus and verdict.
// Depends on rpr_pkg, the block rotary_position_rotation and rotary_position_rotation_check.
module rotary_position_rotation_test;
   import rpr_pkg::*;

   localparam int RANDOM_PAIRS = 500;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  recv_ready;
   logic                  hold_results;

   int mismatches;
   int outstanding;
   int results_seen;
   int clipped_seen;
   int pairs_sent;
   int cycle_count;

   assign rsp_tready = recv_ready & ~hold_results;

   rotary_position_rotation dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   rotary_position_rotation_check checker_inst (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .mismatches   (mismatches),
      .outstanding  (outstanding),
      .results_seen (results_seen),
      .clipped_seen (clipped_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count = cycle_count + 1;
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, outstanding);
      $display("== FAIL ==");
      $finish;
   end

   // Result side: random stalls per transaction, with bursts of full throughput
   initial begin
      int wait_cycles;
      int taken;
      recv_ready = 1'b0;
      taken = 0;
      @(negedge reset);
      forever begin
         wait_cycles = ((taken % 128) < 24) ? 0 : $urandom_range(0, 11);
         repeat (wait_cycles) @(negedge clock) recv_ready <= 1'b0;
         @(negedge clock) recv_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken = taken + 1;
      end
   end

   // Long back-pressure on the result side while pairs keep coming
   initial begin
      hold_results = 1'b0;
      wait (pairs_sent >= 220);
      @(negedge clock) hold_results <= 1'b1;
      repeat (150) @(negedge clock);
      hold_results <= 1'b0;
   end

   task automatic send_pair(input logic backward, input int pos, input int k,
                            input int x, input int y);
      logic [REQ_DATA_W-1:0] word;
      int gap;
      word = '0;
      word[POS_LSB +: POS_BITS]     = pos[POS_BITS-1:0];
      word[PAIR_LSB +: PAIR_BITS]   = k[PAIR_BITS-1:0];
      word[FIRST_LSB +: DATA_BITS]  = x[DATA_BITS-1:0];
      word[SECOND_LSB +: DATA_BITS] = y[DATA_BITS-1:0];
      gap = (hold_results || (pairs_sent % 128) >= 64 && (pairs_sent % 128) < 96) ?
            0 : $urandom_range(0, 11);
      repeat (gap) @(negedge clock) req_tvalid <= 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= backward;
      do @(posedge clock); while (!req_tready);
      pairs_sent = pairs_sent + 1;
   endtask

   function automatic int pick_value();
      case ($urandom_range(0, 7))
         0: return -32768;
         1: return 32767;
         2: return 0;
         default: return $urandom_range(0, 65535) - 32768;
      endcase
   endfunction

   initial begin
      int pos;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      pairs_sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // unit cosine at position zero, full-scale corners, top position and pair index
      send_pair(MODE_FORWARD, 0, 0, 32767, 0);
      send_pair(MODE_BACKWARD, 0, 0, -32768, -32768);
      send_pair(MODE_FORWARD, 0, 31, -32768, 32767);
      send_pair(MODE_FORWARD, 4095, 31, 32767, -32768);
      send_pair(MODE_BACKWARD, 4095, 0, 32767, 32767);
      send_pair(MODE_FORWARD, 4095, 0, -32768, -32768);
      send_pair(MODE_FORWARD, 2048, 16, 0, 0);
      send_pair(MODE_BACKWARD, 1, 1, -1, 1);
      send_pair(MODE_FORWARD, 1234, 5, 4096, -4096);
      // one radian per position walks through every quadrant; full scale clips near 45 deg
      for (int p = 1; p <= 6; p++) begin
         send_pair(MODE_FORWARD, p, 0, 32767, 32767);
         send_pair(MODE_BACKWARD, p, 0, 32767, 32767);
      end

      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         if (i == 350) begin
            @(negedge clock) req_tvalid <= 1'b0;
            while (outstanding != 0) @(negedge clock);
         end
         case ($urandom_range(0, 7))
            0: pos = 0;
            1: pos = 4095;
            default: pos = $urandom_range(0, 4095);
         endcase
         send_pair(1'($urandom_range(0, 1)), pos, $urandom_range(0, 31), pick_value(),
                   pick_value());
      end
      @(negedge clock) req_tvalid <= 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("rotated %0d pairs in both directions over all positions and pair indexes,",
               pairs_sent);
      $display("%0d results checked, %0d clipped, under random and long result stalls",
               results_seen, clipped_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- rotary_position_rotation.f -----
hdl/rpr_pkg.sv
hdl/rpr_cell.sv
hdl/rpr_skid.sv
hdl/rotary_position_rotation.sv
test/rotary_position_rotation_check.sv
test/rotary_position_rotation_test.sv
